[rtl/pas_pkg.sv]
// Package for the Poisson allocation sampler.
// Holds the constants, register indexes and sequencer states; no dependencies.
package pas_pkg;

    localparam int LOG_FRAC_BITS_DEF = 27;

    localparam logic [31:0] MEAN_RESET     = 32'd524288;
    localparam logic [30:0] SEED_RESET     = 31'd1;
    localparam logic [6:0]  OVERHEAD_RESET = 7'd16;

    localparam logic [15:0] PM_MUL  = 16'd48271;
    localparam logic [30:0] PM_MOD  = 31'h7FFFFFFF;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [62:0] WEIGHT_MAX = 63'h7FFFFFFFFFFFFFFF;
    localparam logic [3:0]  GAP_MIN = 4'd8;

    localparam logic [1:0] REG_MEAN     = 2'd0;
    localparam logic [1:0] REG_SEED     = 2'd1;
    localparam logic [1:0] REG_OVERHEAD = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PM_MUL,
        ST_PM_RED,
        ST_NORM,
        ST_SQ_ISSUE,
        ST_SQ_TAKE,
        ST_LN_LO,
        ST_LN_HI,
        ST_LN_SUM,
        ST_GAP_LO,
        ST_GAP_HI,
        ST_GAP_SUM,
        ST_APPLY,
        ST_DIV,
        ST_W_LO,
        ST_W_HI,
        ST_W_SUM,
        ST_DONE
    } pas_state_t;

endpackage

[rtl/poisson_allocation_sampler.sv]
// Poisson allocation sampler, top level.
// Depends on pas_pkg.
//
// One result word per allocation word. An unsampled allocation (credit still
// negative) goes from ST_CHECK to ST_DONE and into the output register, where
// ST_DONE waits while the output register holds a word not yet taken.
// A sampled one runs a sequencer around a single registered 32x32 multiplier
// and a 32-bit compare/subtract: each gap draw normalizes with up to 30 shifts
// and runs a squaring loop for log2, the divide by the mean is bit-serial over
// the 64-bit credit, and the weight takes two multiplies and a sum. The block
// takes no new word until the current one is in the output register.
module poisson_allocation_sampler
    import pas_pkg::*;
#(
    parameter int LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // alloc_size
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // request_size[48:0], weight[111:49]
    output logic [0:0]    m_tuser,   // sampled
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam int FB = LOG_FRAC_BITS;

    pas_state_t state_reg, state_next;

    logic [31:0]   mean_reg;
    logic [6:0]    overhead_reg;
    logic [30:0]   rng_reg, rng_next;
    logic [63:0]   credit_reg, credit_next;
    logic          started_reg, started_next;
    logic          first_reg, first_next;
    logic [47:0]   size_reg, size_next;
    logic [31:0]   m_reg, m_next;
    logic [4:0]    e_reg, e_next;
    logic [FB-1:0] frac_reg, frac_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [63:0]   acc_reg, acc_next;
    logic [63:0]   nl_reg, nl_next;
    logic [63:0]   v_reg, v_next;
    logic [63:0]   n_reg, n_next;
    logic [63:0]   dvd_reg, dvd_next;
    logic [31:0]   rem_reg, rem_next;
    logic [63:0]   mul_p_reg;
    logic [31:0]   mul_a, mul_b;
    logic          res_sampled_reg, res_sampled_next;
    logic [62:0]   res_weight_reg, res_weight_next;
    logic          out_valid_reg, out_valid_next;
    logic [48:0]   out_size_reg, out_size_next;
    logic [62:0]   out_weight_reg, out_weight_next;
    logic          out_sampled_reg, out_sampled_next;

    logic [31:0]  mean_e;
    logic [36:0]  vmax;
    logic [31:0]  fold;
    logic [30:0]  r_val;
    logic [63:0]  log2r;
    logic [63:0]  nneg;
    logic [63:0]  credit_sub;
    logic [32:0]  rem_sh;
    logic         q_bit;
    logic [95:0]  w_total;
    logic [63:0]  v_sum;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_weight_reg, out_size_reg};
    assign m_tuser   = out_sampled_reg;

    assign mean_e = (mean_reg == 32'd0) ? 32'd1 : mean_reg;
    assign vmax   = {1'b0, mean_e, 4'd0} + {3'd0, mean_e, 2'd0};
    assign fold   = {1'b0, mul_p_reg[30:0]} + {16'd0, mul_p_reg[46:31]};
    assign r_val  = (fold >= {1'b0, PM_MOD}) ? 31'(fold - {1'b0, PM_MOD}) : fold[30:0];
    assign log2r  = (64'(e_reg) << FB) | 64'(frac_reg);
    assign nneg   = (64'd31 << FB) - log2r;
    assign credit_sub = credit_reg - v_reg;
    assign rem_sh = {rem_reg, dvd_reg[63]};
    assign q_bit  = (rem_sh >= {1'b0, mean_e});
    assign w_total = {32'd0, acc_reg} + {mul_p_reg, 32'd0};
    assign v_sum  = acc_reg + mul_p_reg;

    always_comb
    begin
        state_next       = state_reg;
        rng_next         = rng_reg;
        credit_next      = credit_reg;
        started_next     = started_reg;
        first_next       = first_reg;
        size_next        = size_reg;
        m_next           = m_reg;
        e_next           = e_reg;
        frac_next        = frac_reg;
        cnt_next         = cnt_reg;
        acc_next         = acc_reg;
        nl_next          = nl_reg;
        v_next           = v_reg;
        n_next           = n_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        res_sampled_next = res_sampled_reg;
        res_weight_next  = res_weight_reg;
        out_valid_next   = out_valid_reg;
        out_size_next    = out_size_reg;
        out_weight_next  = out_weight_reg;
        out_sampled_next = out_sampled_reg;
        mul_a            = 32'd0;
        mul_b            = 32'd0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    size_next   = s_tdata;
                    credit_next = credit_reg + 64'(s_tdata);
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                res_sampled_next = 1'b0;
                res_weight_next  = 63'd0;
                if (credit_reg[63])
                begin
                    state_next = ST_DONE;
                end
                else if (!started_reg)
                begin
                    first_next = 1'b1;
                    state_next = ST_PM_MUL;
                end
                else
                begin
                    first_next = 1'b0;
                    cnt_next   = 6'd0;
                    dvd_next   = credit_reg;
                    rem_next   = 32'd0;
                    state_next = ST_DIV;
                end
            end
            ST_PM_MUL:
            begin
                mul_a      = {1'b0, rng_reg};
                mul_b      = {16'd0, PM_MUL};
                state_next = ST_PM_RED;
            end
            ST_PM_RED:
            begin
                rng_next = r_val;
                if (r_val == 31'd0)
                begin
                    v_next     = 64'(vmax);
                    state_next = ST_GAP_SUM;
                end
                else
                begin
                    m_next     = {1'b0, r_val};
                    e_next     = 5'd30;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (!m_reg[30] && e_reg != 5'd0)
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    e_next = e_reg - 5'd1;
                end
                else
                begin
                    cnt_next   = 6'd0;
                    frac_next  = '0;
                    state_next = ST_SQ_ISSUE;
                end
            end
            ST_SQ_ISSUE:
            begin
                mul_a      = m_reg;
                mul_b      = m_reg;
                state_next = ST_SQ_TAKE;
            end
            ST_SQ_TAKE:
            begin
                frac_next = {frac_reg[FB-2:0], mul_p_reg[61]};
                m_next    = mul_p_reg[61] ? mul_p_reg[62:31] : mul_p_reg[61:30];
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'(FB - 1))
                begin
                    state_next = ST_LN_LO;
                end
                else
                begin
                    state_next = ST_SQ_ISSUE;
                end
            end
            ST_LN_LO:
            begin
                mul_a      = nneg[31:0];
                mul_b      = LN2_Q32;
                state_next = ST_LN_HI;
            end
            ST_LN_HI:
            begin
                acc_next   = {32'd0, mul_p_reg[63:32]};
                mul_a      = nneg[63:32];
                mul_b      = LN2_Q32;
                state_next = ST_LN_SUM;
            end
            ST_LN_SUM:
            begin
                nl_next    = v_sum;
                state_next = ST_GAP_LO;
            end
            ST_GAP_LO:
            begin
                mul_a      = mean_e;
                mul_b      = 32'(nl_reg[FB-1:0]);
                state_next = ST_GAP_HI;
            end
            ST_GAP_HI:
            begin
                acc_next   = mul_p_reg >> FB;
                mul_a      = mean_e;
                mul_b      = 32'(nl_reg >> FB);
                v_next     = 64'd0;
                state_next = ST_GAP_SUM;
            end
            ST_GAP_SUM:
            begin
                priority if (rng_reg == 31'd0 || v_sum > 64'(vmax))
                begin
                    v_next = 64'(vmax);
                end
                else
                begin
                    v_next = v_sum;
                end
                if (rng_reg != 31'd0 && v_sum < 64'(GAP_MIN))
                begin
                    v_next = 64'(GAP_MIN);
                end
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                credit_next = credit_sub;
                if (first_reg)
                begin
                    first_next   = 1'b0;
                    started_next = 1'b1;
                    if (credit_sub[63])
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cnt_next   = 6'd0;
                        dvd_next   = credit_sub;
                        rem_next   = 32'd0;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    n_next = n_reg + 64'd1;
                    if (credit_sub[63])
                    begin
                        state_next = ST_W_LO;
                    end
                    else
                    begin
                        state_next = ST_PM_MUL;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = q_bit ? 32'(rem_sh - {1'b0, mean_e}) : rem_sh[31:0];
                dvd_next = {dvd_reg[62:0], q_bit};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    credit_next = {32'd0, rem_next};
                    n_next      = dvd_next;
                    state_next  = ST_PM_MUL;
                end
            end
            ST_W_LO:
            begin
                mul_a      = n_reg[31:0];
                mul_b      = mean_e;
                state_next = ST_W_HI;
            end
            ST_W_HI:
            begin
                acc_next   = mul_p_reg;
                mul_a      = n_reg[63:32];
                mul_b      = mean_e;
                state_next = ST_W_SUM;
            end
            ST_W_SUM:
            begin
                res_sampled_next = 1'b1;
                res_weight_next  = (w_total[95:63] != 33'd0) ? WEIGHT_MAX : w_total[62:0];
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_sampled_next = res_sampled_reg;
                    out_weight_next  = res_weight_reg;
                    out_size_next    = res_sampled_reg ?
                                       ({1'b0, size_reg} + 49'(overhead_reg)) :
                                       {1'b0, size_reg};
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_index == REG_SEED)
        begin
            rng_next = cfg_data[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mean_reg      <= MEAN_RESET;
            overhead_reg  <= OVERHEAD_RESET;
            rng_reg       <= SEED_RESET;
            credit_reg    <= 64'd0;
            started_reg   <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rng_reg       <= rng_next;
            credit_reg    <= credit_next;
            started_reg   <= started_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_index == REG_MEAN)
            begin
                mean_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_OVERHEAD)
            begin
                overhead_reg <= cfg_data[6:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg        <= size_next;
        m_reg           <= m_next;
        e_reg           <= e_next;
        frac_reg        <= frac_next;
        cnt_reg         <= cnt_next;
        acc_reg         <= acc_next;
        nl_reg          <= nl_next;
        v_reg           <= v_next;
        n_reg           <= n_next;
        dvd_reg         <= dvd_next;
        rem_reg         <= rem_next;
        mul_p_reg       <= 64'(mul_a) * 64'(mul_b);
        res_sampled_reg <= res_sampled_next;
        res_weight_reg  <= res_weight_next;
        out_size_reg    <= out_size_next;
        out_weight_reg  <= out_weight_next;
        out_sampled_reg <= out_sampled_next;
    end

endmodule

[bench/pas_checker.sv]
// Scoreboard for the Poisson allocation sampler: watches the input, output and
// config channels, predicts each result word and compares it with the word taken.
// Depends on pas_pkg.
module pas_checker
    import pas_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [47:0]   s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [111:0]  m_tdata,
    input  logic [0:0]    m_tuser,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output int            errors,
    output int            pending,
    output int            sampled_count,
    output int            result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [48:0] request_size;
        logic [62:0] weight;
        logic        sampled;
    } alloc_result_t;

    logic [31:0] mean_reg;
    logic [6:0]  overhead_reg;
    logic [63:0] rng;
    logic [63:0] credit;
    logic        started;

    alloc_result_t expected_q[$];

    function automatic logic [63:0] neg_ln(input logic [63:0] r);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] nl2;
        e = 30;
        while (e > 0 && !r[e])
            e--;
        m = r << (30 - e);
        frac = 0;
        for (int i = 0; i < LOG_FRAC_BITS_DEF; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000)
            begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        nl2 = (64'd31 << LOG_FRAC_BITS_DEF) - ((64'(e) << LOG_FRAC_BITS_DEF) | frac);
        return (nl2 >> 32) * 64'(LN2_Q32)
             + (((nl2 & 64'hFFFF_FFFF) * 64'(LN2_Q32)) >> 32);
    endfunction

    function automatic logic [63:0] draw_gap(input logic [63:0] mean);
        logic [63:0] vmax;
        logic [63:0] v;
        logic [63:0] nl;
        rng = (rng * 64'(PM_MUL)) % 64'(PM_MOD);
        vmax = 64'd20 * mean;
        if (rng == 0)
            v = vmax;
        else
        begin
            nl = neg_ln(rng);
            v = mean * (nl >> LOG_FRAC_BITS_DEF)
              + ((mean * (nl & ((64'd1 << LOG_FRAC_BITS_DEF) - 1))) >> LOG_FRAC_BITS_DEF);
        end
        if (v > vmax)
            v = vmax;
        if (v < 64'(GAP_MIN))
            v = 64'(GAP_MIN);
        return v;
    endfunction

    function automatic alloc_result_t sample_alloc(input logic [47:0] size);
        alloc_result_t res;
        logic [63:0]   mean;
        logic [63:0]   n;
        credit = credit + 64'(size);
        res.request_size = 49'(size);
        res.weight = '0;
        res.sampled = 1'b0;
        if (!credit[63])
        begin
            mean = (mean_reg == 0) ? 64'd1 : 64'(mean_reg);
            if (!started)
            begin
                credit = credit - draw_gap(mean);
                started = 1'b1;
            end
            if (!credit[63])
            begin
                n = credit / mean;
                credit = credit % mean;
                do
                begin
                    credit = credit - draw_gap(mean);
                    n++;
                end while (!credit[63]);
                res.weight = (n > 64'(WEIGHT_MAX) / mean) ? WEIGHT_MAX : 63'(n * mean);
                res.request_size = 49'(size) + 49'(overhead_reg);
                res.sampled = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        alloc_result_t got;
        if (!rst_n)
        begin
            mean_reg <= MEAN_RESET;
            overhead_reg <= OVERHEAD_RESET;
            rng = 64'(SEED_RESET);
            credit = '0;
            started = 1'b0;
            errors <= 0;
            pending <= 0;
            sampled_count <= 0;
            result_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MEAN: mean_reg <= cfg_data;
                    REG_SEED: rng = 64'(cfg_data[30:0]);
                    REG_OVERHEAD: overhead_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(sample_alloc(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.request_size = m_tdata[48:0];
                got.weight = m_tdata[111:49];
                got.sampled = m_tuser[0];
                result_count <= result_count + 1;
                if (got.sampled)
                    sampled_count <= sampled_count + 1;
                if (expected_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%t unexpected result word req=%0d weight=%0d sampled=%0d",
                                 $realtime, got.request_size, got.weight, got.sampled);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want != got)
                    begin
                        if (errors < 10)
                            $display("%t mismatch: req %0d/%0d weight %0d/%0d sampled %0d/%0d",
                                     $realtime, want.request_size, got.request_size,
                                     want.weight, got.weight, want.sampled, got.sampled);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

[bench/testbench.sv]
// Top of the sampler bench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on pas_pkg, poisson_allocation_sampler and pas_checker.
module testbench;
    import pas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [47:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [111:0]  m_tdata;
    logic [0:0]    m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = REG_MEAN;
    logic [31:0]   cfg_data = '0;

    int errors;
    int pending;
    int sampled_count;
    int result_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_no = 0;
    int hold_left = 0;
    bit held = 1'b0;

    localparam logic [47:0] SIZE_MAX = 48'hFFFF_FFFF_FFFF;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    poisson_allocation_sampler dut (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    pas_checker scoreboard (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .pending, .sampled_count, .result_count
    );

    // receiver; one long hold-off in phase 1 to back the block up
    always @(posedge clk)
    begin
        if (phase_no == 1 && !held)
        begin
            held <= 1'b1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_alloc(input logic [47:0] size);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= size;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [47:0] pick_size(input logic [31:0] mean);
        logic [63:0] span;
        span = (mean == 0) ? 64'd3 : 64'd3 * 64'(mean);
        case ($urandom_range(9))
            0: return 48'({$urandom, $urandom});
            1: return '0;
            2: return SIZE_MAX;
            default: return 48'(({$urandom, $urandom}) % (span + 1));
        endcase
    endfunction

    initial
    begin
        logic [31:0] mean;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, then the extremes
        send_alloc(48'd0);
        send_alloc(48'd1);
        send_alloc(48'd524288);
        send_alloc(SIZE_MAX);
        send_alloc(48'd0);
        drain();
        write_reg(REG_MEAN, 32'd0);
        write_reg(REG_SEED, 32'd2147483646);
        write_reg(REG_OVERHEAD, 32'd0);
        send_alloc(48'd0);
        send_alloc(48'd1);
        send_alloc(48'd8);
        send_alloc(48'd100);
        send_alloc(SIZE_MAX);
        drain();
        write_reg(REG_MEAN, 32'hFFFF_FFFF);
        write_reg(REG_OVERHEAD, 32'd64);
        write_reg(REG_SEED, 32'd0);
        send_alloc(SIZE_MAX);
        send_alloc(SIZE_MAX);
        send_alloc(48'd5);
        drain();
        write_reg(REG_MEAN, 32'd1);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        write_reg(REG_OVERHEAD, 32'd127);
        send_alloc(48'd1);
        send_alloc(48'd7);
        send_alloc(48'd1000);
        send_alloc(SIZE_MAX);
        drain();

        // random phases over the four idle patterns
        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(5))
                0: mean = 32'd1;
                1: mean = $urandom_range(64, 2);
                2: mean = $urandom_range(5000, 100);
                3: mean = MEAN_RESET;
                4: mean = $urandom;
                default: mean = 32'd0;
            endcase
            if (p == 0)
                mean = 32'd0;
            if (p == 7)
                mean = 32'hFFFF_FFFF;
            write_reg(REG_MEAN, mean);
            write_reg(REG_SEED, $urandom_range(32'd2147483646, 1));
            write_reg(REG_OVERHEAD, $urandom_range(64));
            send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 62 : 27) : 0;
            recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 2) ? 62 : 27) : 0;
            phase_no = p;
            for (int i = 0; i < 117; i++)
                send_alloc(pick_size(mean));
            drain();
        end

        $display("covered %0d result words, %0d sampled, across 8 random phases",
                 result_count, sampled_count);
        $display("with means from 0 to 2^32-1, extreme seeds and overheads");
        if (errors == 0)
            $display("[poisson_allocation_sampler] OK");
        else
            $display("[poisson_allocation_sampler] ERROR");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("[poisson_allocation_sampler] ERROR");
        $finish;
    end
endmodule

[sim.f]
rtl/pas_pkg.sv
rtl/poisson_allocation_sampler.sv
bench/pas_checker.sv
bench/testbench.sv
